// ===== sv/bbm_pkg.sv =====
// Shared types and constants for the box blur block.
// Transaction payload structs, register indexes and lane control.
// No dependencies.
`timescale 1ns / 1ps

package bbm_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [10:0] RST_HEIGHT = 11'd480;
  localparam logic [2:0]  RST_RADIUS = 3'd5;

  typedef struct packed {
    logic       is_pixel;
    logic [7:0] chan_blue;
    logic [7:0] chan_green;
    logic [7:0] chan_red;
  } in_t;

  typedef struct packed {
    logic [7:0] blur_blue;
    logic [7:0] blur_green;
    logic [7:0] blur_red;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       frame_done;
  } out_t;

  // Controls sent from the sequencer to every channel lane
  typedef struct packed {
    logic clr;
    logic add;
    logic start;
  } lane_ctl_t;

endpackage

// ===== sv/bbm_lane.sv =====
// One channel lane: accumulates window samples, then divides by the count.
// Restoring divider, one quotient bit per cycle. Uses bbm_pkg.
`timescale 1ns / 1ps

module bbm_lane #(
  parameter int SUM_W = 16,
  parameter int CNT_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbm_pkg::lane_ctl_t ctl_i,
  input  logic [7:0]         sample_i,
  input  logic [CNT_W-1:0]   count_i,
  output logic               busy_o,
  output logic [7:0]         mean_o
);

  localparam int IW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] acc_q, acc_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [IW-1:0]    iter_q, iter_d;
  logic             busy_q, busy_d;
  logic [CNT_W:0]   rem_sh;

  assign rem_sh = {rem_q, quo_q[SUM_W-1]};

  // Accumulate, then shift-subtract division
  always_comb begin
    acc_d  = acc_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    iter_d = iter_q;
    busy_d = busy_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = acc_q + SUM_W'(sample_i);
    end
    if (ctl_i.start) begin
      quo_d  = acc_q;
      rem_d  = '0;
      iter_d = IW'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, count_i}) begin
        rem_d = CNT_W'(rem_sh - {1'b0, count_i});
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      iter_d = iter_q - IW'(1);
      if (iter_q == IW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign mean_o = quo_q[7:0];

endmodule

// ===== sv/box_blur_border_mean.sv =====
// Streaming box blur, top level: row store, window sequencer, three lanes.
// A transaction that yields a result runs check, window scan (one store
// read per cycle over up to (2*radius+1)^2 window pixels), divide and load
// before out_valid_o rises. One transaction in flight: the next one is
// accepted once the block is back in idle, later while the output is stalled.
// Reset: 640x480, radius 5; positions cleared.
`timescale 1ns / 1ps

module box_blur_border_mean #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  bbm_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output bbm_pkg::out_t out_data_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int SLOTS = 2 * MAX_RADIUS + 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = $clog2(SLOTS * MAX_WIDTH);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LW    = RDW + CW + 1;
  localparam int MW    = (PW > LW) ? PW : LW;
  localparam int SIDE  = 2 * MAX_RADIUS + 1;
  localparam int KW    = $clog2(SIDE + 1);
  localparam int CNT_W = $clog2(SIDE * SIDE + 1);
  localparam int SUM_W = CNT_W + 8;
  localparam int NL    = 3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SCAN, ST_LAST, ST_DIVS, ST_DIVW, ST_LOAD
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [10:0] cfg_w_q, cfg_h_q;
  logic [2:0]  cfg_r_q;
  logic        cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      bbm_pkg::REG_WIDTH:  prdata = 32'(cfg_w_q);
      bbm_pkg::REG_HEIGHT: prdata = 32'(cfg_h_q);
      bbm_pkg::REG_RADIUS: prdata = 32'(cfg_r_q);
      default:             prdata = '0;
    endcase
  end

  // Effective, clamped configuration
  logic [CW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;
  logic [RDW-1:0] rad;
  logic [SW-1:0]  slot_max;
  logic [LW-1:0]  lag;
  logic [CW-1:0]  w_m1;

  always_comb begin
    if (cfg_w_q == 11'd0)               w_eff = CW'(1);
    else if (int'(cfg_w_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else                                w_eff = CW'(cfg_w_q);
    if (cfg_h_q == 11'd0)                h_eff = RW'(1);
    else if (int'(cfg_h_q) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else                                 h_eff = RW'(cfg_h_q);
    if (int'(cfg_r_q) > MAX_RADIUS) rad = RDW'(MAX_RADIUS);
    else                            rad = RDW'(cfg_r_q);
    slot_max = SW'({rad, 1'b1});
    w_m1     = w_eff - CW'(1);
    lag      = LW'(LW'(rad) * LW'(w_eff))
             + ((CW'(rad) < w_m1) ? LW'(rad) : LW'(w_m1));
  end

  // Frame position state
  logic [RW-1:0] in_row_q, emit_row_q;
  logic [CW-1:0] in_col_q, emit_col_q;
  logic [SW-1:0] in_slot_q, emit_slot_q;
  logic [PW-1:0] pend_q;
  logic          frame_in_q;

  // Window scan state
  logic [RW-1:0]    r_q, r1_q;
  logic [CW-1:0]    c_q, c0_q, c1_q;
  logic [SW-1:0]    slot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd_v_q;

  // Window bounds around the next output pixel
  logic [RW:0]   r0_w, r1_w, er_plus;
  logic [CW:0]   c0_w, c1_w, ec_plus;
  logic [SW-1:0] row_back, start_slot;
  logic [KW-1:0] nrows, ncols;
  logic          emit_due, last_px;

  always_comb begin
    r0_w    = (emit_row_q >= RW'(rad)) ? (RW+1)'(emit_row_q - RW'(rad)) : '0;
    er_plus = (RW+1)'(emit_row_q) + (RW+1)'(rad);
    r1_w    = (er_plus < (RW+1)'(h_eff)) ? er_plus : (RW+1)'(h_eff - RW'(1));
    c0_w    = (emit_col_q >= CW'(rad)) ? (CW+1)'(emit_col_q - CW'(rad)) : '0;
    ec_plus = (CW+1)'(emit_col_q) + (CW+1)'(rad);
    c1_w    = (ec_plus < (CW+1)'(w_eff)) ? ec_plus : (CW+1)'(w_m1);
    row_back = SW'(emit_row_q - RW'(r0_w));
    if (emit_slot_q >= row_back) start_slot = emit_slot_q - row_back;
    else start_slot = SW'(emit_slot_q + slot_max + SW'(1) - row_back);
    nrows    = KW'(r1_w - r0_w + (RW+1)'(1));
    ncols    = KW'(c1_w - c0_w + (CW+1)'(1));
    emit_due = frame_in_q || (MW'(pend_q) > MW'(lag));
    last_px  = (emit_row_q == h_eff - RW'(1)) && (emit_col_q == w_m1);
  end

  // Row store: one write port, one registered read port
  logic [23:0]   mem [SLOTS * MAX_WIDTH];
  logic [23:0]   rd_data_q;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;

  assign wr_addr = AW'(AW'(in_slot_q) * AW'(MAX_WIDTH)) + AW'(in_col_q);
  assign rd_addr = AW'(AW'(slot_q) * AW'(MAX_WIDTH)) + AW'(c_q);
  assign wr_en   = (state_q == ST_IDLE) && in_valid_i && in_data_i.is_pixel
                   && !frame_in_q && !cfg_wr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_data_i.chan_red, in_data_i.chan_green, in_data_i.chan_blue};
    end
    if (state_q == ST_SCAN) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Channel lanes
  bbm_pkg::lane_ctl_t lane_ctl;
  logic [NL-1:0]      lane_busy;
  logic [7:0]         lane_mean [NL];

  assign lane_ctl.clr   = (state_q == ST_CHECK);
  assign lane_ctl.add   = rd_v_q;
  assign lane_ctl.start = (state_q == ST_DIVS);

  for (genvar g = 0; g < NL; g++) begin : g_lane
    bbm_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (lane_ctl),
      .sample_i(rd_data_q[8*g +: 8]),
      .count_i (cnt_q),
      .busy_o  (lane_busy[g]),
      .mean_o  (lane_mean[g])
    );
  end

  // Output register
  logic          out_valid_q;
  bbm_pkg::out_t out_q;
  logic          out_free;
  logic          out_load;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_LOAD) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_wr;

  // Sequencer, positions and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_w_q     <= bbm_pkg::RST_WIDTH;
      cfg_h_q     <= bbm_pkg::RST_HEIGHT;
      cfg_r_q     <= bbm_pkg::RST_RADIUS;
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_slot_q   <= '0;
      emit_row_q  <= '0;
      emit_col_q  <= '0;
      emit_slot_q <= '0;
      pend_q      <= '0;
      frame_in_q  <= 1'b0;
      r_q         <= '0;
      r1_q        <= '0;
      c_q         <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
      slot_q      <= '0;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rd_v_q <= (state_q == ST_SCAN);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cfg_wr && (paddr[3:2] inside {bbm_pkg::REG_WIDTH, bbm_pkg::REG_HEIGHT,
                                            bbm_pkg::REG_RADIUS})) begin
            case (paddr[3:2])
              bbm_pkg::REG_WIDTH:  cfg_w_q <= pwdata[10:0];
              bbm_pkg::REG_HEIGHT: cfg_h_q <= pwdata[10:0];
              bbm_pkg::REG_RADIUS: cfg_r_q <= pwdata[2:0];
              default:             ;
            endcase
            in_row_q    <= '0;
            in_col_q    <= '0;
            in_slot_q   <= '0;
            emit_row_q  <= '0;
            emit_col_q  <= '0;
            emit_slot_q <= '0;
            pend_q      <= '0;
            frame_in_q  <= 1'b0;
          end else if (in_valid_i && !cfg_wr) begin
            if (wr_en) begin
              pend_q <= pend_q + PW'(1);
              if (in_col_q == w_m1) begin
                in_col_q  <= '0;
                in_row_q  <= in_row_q + RW'(1);
                in_slot_q <= (in_slot_q == slot_max) ? '0 : in_slot_q + SW'(1);
                if (in_row_q + RW'(1) >= h_eff) begin
                  frame_in_q <= 1'b1;
                end
              end else begin
                in_col_q <= in_col_q + CW'(1);
              end
            end
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (emit_due) begin
            r_q     <= RW'(r0_w);
            r1_q    <= RW'(r1_w);
            c_q     <= CW'(c0_w);
            c0_q    <= CW'(c0_w);
            c1_q    <= CW'(c1_w);
            slot_q  <= start_slot;
            cnt_q   <= CNT_W'(CNT_W'(nrows) * CNT_W'(ncols));
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (c_q == c1_q) begin
            c_q <= c0_q;
            if (r_q == r1_q) begin
              state_q <= ST_LAST;
            end else begin
              r_q    <= r_q + RW'(1);
              slot_q <= (slot_q == slot_max) ? '0 : slot_q + SW'(1);
            end
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        ST_LAST: begin
          state_q <= ST_DIVS;
        end
        ST_DIVS: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          if (lane_busy == '0) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            out_q.blur_blue  <= lane_mean[0];
            out_q.blur_green <= lane_mean[1];
            out_q.blur_red   <= lane_mean[2];
            out_q.out_row    <= 10'(emit_row_q);
            out_q.out_col    <= 10'(emit_col_q);
            out_q.frame_done <= last_px;
            if (last_px) begin
              in_row_q    <= '0;
              in_col_q    <= '0;
              in_slot_q   <= '0;
              emit_row_q  <= '0;
              emit_col_q  <= '0;
              emit_slot_q <= '0;
              pend_q      <= '0;
              frame_in_q  <= 1'b0;
            end else begin
              pend_q <= pend_q - PW'(1);
              if (emit_col_q == w_m1) begin
                emit_col_q  <= '0;
                emit_row_q  <= emit_row_q + RW'(1);
                emit_slot_q <= (emit_slot_q == slot_max) ? '0 : emit_slot_q + SW'(1);
              end else begin
                emit_col_q <= emit_col_q + CW'(1);
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb_box_blur_border_mean.sv =====
// Testbench for the streaming box blur: directed table and cases, random frames.
// A behavioral blur predictor checks every output transaction field by field.
// Depends on bbm_pkg and box_blur_border_mean.
`timescale 1ns / 1ps

module tb_box_blur_border_mean;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int MAXR = 7;
  localparam int SLOT_MAX = 2 * MAXR + 2;
  localparam int WATCHDOG = 400000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  bbm_pkg::in_t  in_data;
  bbm_pkg::out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  box_blur_border_mean uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  logic [10:0] cfg_w, cfg_h;
  logic [2:0]  cfg_r;
  logic [23:0] pix_rows [SLOT_MAX * MAXW];
  int unsigned wr_row, wr_col, em_row, em_col;
  bit          got_frame;

  bbm_pkg::out_t blur_queue[$];
  int   err_count = 0;
  int   idle_cycles = 0;
  bit   hold_long;
  int   pre_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned m);
    if (v == 0) return 1;
    return (v > m) ? m : v;
  endfunction

  function automatic void restart_frame();
    wr_row = 0; wr_col = 0; em_row = 0; em_col = 0; got_frame = 0;
  endfunction

  // One input transaction through the blur predictor; pushes its output if any
  function automatic void blur_step(input bbm_pkg::in_t item);
    int unsigned w, h, rad, slots, lag, recv, eidx, r0, r1, c0, c1;
    int unsigned sb, sg, sr, cnt;
    logic [23:0] px;
    bbm_pkg::out_t o;
    bit last;
    w = clamp_dim(cfg_w, MAXW);
    h = clamp_dim(cfg_h, MAXH);
    rad = cfg_r;
    slots = 2 * rad + 2;
    lag = rad * w + ((rad < w - 1) ? rad : w - 1);
    if (item.is_pixel && !got_frame) begin
      pix_rows[(wr_row % slots) * MAXW + wr_col] =
        {item.chan_red, item.chan_green, item.chan_blue};
      wr_col++;
      if (wr_col >= w) begin
        wr_col = 0;
        wr_row++;
        if (wr_row >= h) got_frame = 1;
      end
    end
    recv = wr_row * w + wr_col;
    eidx = em_row * w + em_col;
    if (!got_frame && recv < eidx + lag + 1) return;
    r0 = (em_row >= rad) ? em_row - rad : 0;
    r1 = (em_row + rad < h) ? em_row + rad : h - 1;
    c0 = (em_col >= rad) ? em_col - rad : 0;
    c1 = (em_col + rad < w) ? em_col + rad : w - 1;
    sb = 0; sg = 0; sr = 0; cnt = 0;
    for (int unsigned r = r0; r <= r1; r++)
      for (int unsigned c = c0; c <= c1; c++) begin
        px = pix_rows[(r % slots) * MAXW + c];
        sb += px[7:0]; sg += px[15:8]; sr += px[23:16];
        cnt++;
      end
    last = (em_row == h - 1) && (em_col == w - 1);
    o.blur_blue  = 8'(sb / cnt);
    o.blur_green = 8'(sg / cnt);
    o.blur_red   = 8'(sr / cnt);
    o.out_row    = 10'(em_row);
    o.out_col    = 10'(em_col);
    o.frame_done = last;
    blur_queue.push_back(o);
    if (last) restart_frame();
    else begin
      em_col++;
      if (em_col >= w) begin
        em_col = 0;
        em_row++;
      end
    end
  endfunction

  // Register write over APB; block must be idle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == bbm_pkg::REG_WIDTH) cfg_w = val[10:0];
    else if (idx == bbm_pkg::REG_HEIGHT) cfg_h = val[10:0];
    else cfg_r = val[2:0];
    restart_frame();
  endtask

  // Drop valid, then wait for every predicted output plus a quiet stretch
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (blur_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Valid stays up between back-to-back transactions; a gap drops it first
  task automatic send_item(input bbm_pkg::in_t item, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    blur_step(item);
  endtask

  function automatic bbm_pkg::in_t rand_pixel();
    bbm_pkg::in_t p;
    p = bbm_pkg::in_t'($urandom);
    p.is_pixel = 1'b1;
    return p;
  endfunction

  // Whole frame plus drain ticks until frame_done is predicted
  task automatic send_frame(input int noise);
    int unsigned n;
    bbm_pkg::in_t t;
    n = clamp_dim(cfg_w, MAXW) * clamp_dim(cfg_h, MAXH);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise) begin
        t = bbm_pkg::in_t'($urandom);
        t.is_pixel = 1'b0;
        send_item(t, 1);
      end
      send_item(rand_pixel(), 1);
    end
    while (got_frame) begin
      t = bbm_pkg::in_t'($urandom);
      if ($urandom_range(0, 3) != 0) t.is_pixel = 1'b0;
      send_item(t, 1);
    end
  endtask

  typedef struct {
    bbm_pkg::in_t  item;
    bit            has_want;
    bbm_pkg::out_t want;
  } dir_row_t;

  // Receiver: random stall per transaction, one long hold-off
  initial begin
    int waitn;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end
      waitn = $urandom_range(0, 17);
      if ($urandom_range(0, 2) == 0) waitn = 0;
      if (waitn > 0) begin
        out_stall <= 1'b1;
        repeat (waitn) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Output checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (blur_queue.size() == 0) report("unexpected output", 0, 0);
        else begin
          bbm_pkg::out_t e;
          e = blur_queue.pop_front();
          if (out_data.blur_blue != e.blur_blue)
            report("blur_blue", out_data.blur_blue, e.blur_blue);
          if (out_data.blur_green != e.blur_green)
            report("blur_green", out_data.blur_green, e.blur_green);
          if (out_data.blur_red != e.blur_red)
            report("blur_red", out_data.blur_red, e.blur_red);
          if (out_data.out_row != e.out_row)
            report("out_row", out_data.out_row, e.out_row);
          if (out_data.out_col != e.out_col)
            report("out_col", out_data.out_col, e.out_col);
          if (out_data.frame_done != e.frame_done)
            report("frame_done", out_data.frame_done, e.frame_done);
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    dir_row_t row;
    hold_long = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_w = bbm_pkg::RST_WIDTH; cfg_h = bbm_pkg::RST_HEIGHT; cfg_r = bbm_pkg::RST_RADIUS;
    restart_frame();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 1x1 frame, radius 0: output equals input at extremes
    reg_write(bbm_pkg::REG_WIDTH, 32'd1);
    reg_write(bbm_pkg::REG_HEIGHT, 32'd1);
    reg_write(bbm_pkg::REG_RADIUS, 32'd0);
    row = '{item: '{1'b0, 8'hFF, 8'hFF, 8'hFF}, has_want: 0, want: '0};
    dir_tab.push_back(row); // drain tick before the frame: nothing
    row = '{item: '{1'b1, 8'hFF, 8'h00, 8'hFF}, has_want: 1,
            want: '{8'hFF, 8'h00, 8'hFF, 10'd0, 10'd0, 1'b1}};
    dir_tab.push_back(row);
    row = '{item: '{1'b1, 8'h00, 8'hFF, 8'h00}, has_want: 1,
            want: '{8'h00, 8'hFF, 8'h00, 10'd0, 10'd0, 1'b1}};
    dir_tab.push_back(row);
    row = '{item: '{1'b1, 8'h5A, 8'hA5, 8'h3C}, has_want: 0, want: '0};
    dir_tab.push_back(row);
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].item, 0);
      if (dir_tab[i].has_want && blur_queue.size() != 0 &&
          blur_queue[$] != dir_tab[i].want)
        report("directed row", i, 0);
    end
    wait_idle();

    // Zero width and height act as 1, radius 7 saturates the window
    reg_write(bbm_pkg::REG_WIDTH, 32'd0);
    reg_write(bbm_pkg::REG_HEIGHT, 32'd0);
    reg_write(bbm_pkg::REG_RADIUS, 32'd7);
    send_frame(0);
    wait_idle();

    // 3x3 frame, radius 7, pixels mixed with non-pixel items, then drain items that may hold pixels
    reg_write(bbm_pkg::REG_WIDTH, 32'd3);
    reg_write(bbm_pkg::REG_HEIGHT, 32'd3);
    send_frame(20);
    wait_idle();

    // Oversized width, one row, radius 0 so every pixel yields an output;
    // the receiver holds off once while the sender still has pixels to send
    reg_write(bbm_pkg::REG_WIDTH, 32'h7FF);
    reg_write(bbm_pkg::REG_HEIGHT, 32'd1);
    reg_write(bbm_pkg::REG_RADIUS, 32'd0);
    pre_hold = 20;
    for (int unsigned i = 0; i < 100; i++) begin
      if (i == pre_hold) hold_long = 1;
      send_item(rand_pixel(), i > 60);
    end
    wait_idle();

    // Frame aborted by a register write mid-frame
    reg_write(bbm_pkg::REG_WIDTH, 32'd4);
    reg_write(bbm_pkg::REG_HEIGHT, 32'd4);
    reg_write(bbm_pkg::REG_RADIUS, 32'd2);
    repeat (7) send_item(rand_pixel(), 1);
    wait_idle();
    reg_write(bbm_pkg::REG_RADIUS, 32'd2);

    // Random frames with random small sizes and radius
    for (int k = 0; k < 26; k++) begin
      reg_write(bbm_pkg::REG_WIDTH, $urandom_range(1, 9) | ($urandom_range(0, 1) << 11));
      reg_write(bbm_pkg::REG_HEIGHT, $urandom_range(1, 7));
      reg_write(bbm_pkg::REG_RADIUS, $urandom_range(0, 7));
      send_frame(8);
      wait_idle(); // sender pauses until all results are in
    end

    // Tall narrow frame with oversized height, first rows only
    reg_write(bbm_pkg::REG_WIDTH, 32'd1);
    reg_write(bbm_pkg::REG_HEIGHT, 32'h7FF);
    reg_write(bbm_pkg::REG_RADIUS, 32'd2);
    repeat (30) send_item(rand_pixel(), 1);
    wait_idle();

    if (blur_queue.size() != 0) report("left over", blur_queue.size(), 0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bbm_pkg.sv
sv/bbm_lane.sv
sv/box_blur_border_mean.sv
test/tb_box_blur_border_mean.sv
